// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define PPE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, but also checked during reset.
`define PPE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ppe_pkg.sv =====
`timescale 1ns / 1ps
package ppe_pkg;

  localparam int MAX_BODIES = 64;
  localparam int IDX_W = $clog2(MAX_BODIES);
  localparam int CNT_W = $clog2(MAX_BODIES + 1);

  localparam logic [31:0] GRAVITY_RESET = 32'd65536;
  localparam logic [23:0] SOFTENING_RESET = 24'd5120;

  localparam logic REG_GRAVITY = 1'b0;
  localparam logic REG_SOFTENING = 1'b1;

  typedef struct packed {
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
    logic [23:0] radius;
    logic [31:0] mass;
  } body_t;

  localparam int BODY_W = $bits(body_t);

endpackage

// ===== rtl/pairwise_potential_energy.sv =====
`timescale 1ns / 1ps
// Softened pairwise gravitational potential energy.
// Slave stream: one body per word (mass, radius, x, y, z); tlast marks the
// final body and starts the pair pass. s_tready is high only while loading.
// Bodies beyond the store depth are dropped and flag overflow.
// Loading takes one body per cycle. The pass runs every unordered pair
// through one sequencer: it reads both bodies, sums the squared distances,
// forms the numerator, then runs the 35-step square root and the 96-step
// restoring divider; the divider is skipped when the mass product or the
// denominator is zero. There are n*(n-1)/2 pairs for n bodies.
// Master stream: one word per set, energy and body count in tdata, overflow
// in tuser. The word sits in an output register; a stalled receiver holds
// it there, and the next set may load meanwhile, but a finished pass waits
// until the previous word is taken.
// APB: gravity_scale at 0x0, softening at 0x4, pready always high.
// Synchronous reset sets the registers to 1.0 and 20.0 and empties the
// store; no clearing pass is needed.
module pairwise_potential_energy (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [151:0] s_tdata,  // mass, radius, pos_x, pos_y, pos_z
  input  logic         s_tlast,  // last_body
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata,  // energy, body_count, zero pad
  output logic         m_tuser,  // overflow
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_START = 5'd1;
  localparam logic [4:0] S_RDI   = 5'd2;
  localparam logic [4:0] S_LATI  = 5'd3;
  localparam logic [4:0] S_RDJ   = 5'd4;
  localparam logic [4:0] S_LATJ  = 5'd5;
  localparam logic [4:0] S_SQ0   = 5'd6;
  localparam logic [4:0] S_SQ1   = 5'd7;
  localparam logic [4:0] S_SQ2   = 5'd8;
  localparam logic [4:0] S_SQ3   = 5'd9;
  localparam logic [4:0] S_NM1   = 5'd10;
  localparam logic [4:0] S_NM2   = 5'd11;
  localparam logic [4:0] S_NM3   = 5'd12;
  localparam logic [4:0] S_SQRT  = 5'd13;
  localparam logic [4:0] S_DEN   = 5'd14;
  localparam logic [4:0] S_DIV   = 5'd15;
  localparam logic [4:0] S_ACC   = 5'd16;
  localparam logic [4:0] S_NEXT  = 5'd17;
  localparam logic [4:0] S_DONE  = 5'd18;

  localparam logic [63:0] CAP = 64'h8000_0000_0000_0000;

  logic [4:0] state;
  logic [ppe_pkg::CNT_W-1:0] cnt, i_idx, j_idx;
  logic dropped;
  logic [31:0] gravity;
  logic [23:0] softening;
  logic emit;

  ppe_pkg::body_t ei, ej, rd_body;
  logic [ppe_pkg::BODY_W-1:0] rdata;
  logic [ppe_pkg::IDX_W-1:0] raddr;
  logic we;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [65:0] ssum;
  logic [31:0] gm_hi;
  logic [63:0] nlo;
  logic [95:0] num;
  logic [69:0] sh;
  logic [34:0] root;
  logic [37:0] srem;
  logic [6:0] step;
  logic [35:0] den;
  logic [43:0] drem;
  logic [95:0] dn;
  logic [63:0] mag;
  logic ovf;
  logic [63:0] energy_o;
  logic [6:0] count_o;
  logic ovf_o;

  logic [37:0] s_rem2, s_trial;
  logic s_ge;
  logic [44:0] d_rem2, d_div;
  logic d_ge;
  logic [35:0] den_c;
  logic [34:0] dmax;

  function automatic logic [31:0] absdiff(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    return d[32] ? 32'(-d) : d[31:0];
  endfunction

  ppe_ram #(.WIDTH(ppe_pkg::BODY_W), .DEPTH(ppe_pkg::MAX_BODIES)) u_store (
    .clk(clk), .we(we), .waddr(cnt[ppe_pkg::IDX_W-1:0]), .wdata(s_tdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign rd_body = ppe_pkg::body_t'(rdata);
  assign s_tready = (state == S_IDLE);
  assign we = s_tvalid && s_tready && (cnt < ppe_pkg::CNT_W'(ppe_pkg::MAX_BODIES));
  assign raddr = (state == S_RDI) ? i_idx[ppe_pkg::IDX_W-1:0] : j_idx[ppe_pkg::IDX_W-1:0];
  assign emit = (state == S_DONE) && (!m_tvalid || m_tready);

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ppe_pkg::REG_SOFTENING) ? {8'd0, softening} : gravity;

  assign m_tdata = {1'b0, count_o, energy_o};
  assign m_tuser = ovf_o;

  always_comb begin
    mul_a = absdiff(ei.pos_x, ej.pos_x);
    mul_b = mul_a;
    case (state)
      S_SQ1: begin
        mul_a = absdiff(ei.pos_y, ej.pos_y);
        mul_b = mul_a;
      end
      S_SQ2: begin
        mul_a = absdiff(ei.pos_z, ej.pos_z);
        mul_b = mul_a;
      end
      S_SQ3: begin
        mul_a = gravity;
        mul_b = ei.mass;
      end
      S_NM1: begin
        mul_a = prod[31:0];
        mul_b = ej.mass;
      end
      S_NM2: begin
        mul_a = gm_hi;
        mul_b = ej.mass;
      end
      default: ;
    endcase
  end

  always_comb begin
    s_rem2 = {srem[35:0], sh[69:68]};
    s_trial = {1'b0, root, 2'b01};
    s_ge = (s_rem2 >= s_trial);
    d_rem2 = {drem, dn[95]};
    d_div = {1'b0, den, 8'd0};
    d_ge = (d_rem2 >= d_div);
    dmax = (root < 35'({1'b0, ei.radius} + {1'b0, ej.radius})) ?
           35'({1'b0, ei.radius} + {1'b0, ej.radius}) : root;
    den_c = {1'b0, dmax} + 36'(softening);
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      dropped <= 1'b0;
      m_tvalid <= 1'b0;
      gravity <= ppe_pkg::GRAVITY_RESET;
      softening <= ppe_pkg::SOFTENING_RESET;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == ppe_pkg::REG_SOFTENING) begin
          softening <= pwdata[23:0];
        end else begin
          gravity <= pwdata;
        end
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (we) begin
              cnt <= cnt + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
            if (s_tlast) begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          mag <= '0;
          ovf <= dropped;
          i_idx <= '0;
          state <= (cnt < ppe_pkg::CNT_W'(2)) ? S_DONE : S_RDI;
        end
        S_RDI: state <= S_LATI;
        S_LATI: begin
          ei <= rd_body;
          j_idx <= i_idx + 1'b1;
          state <= S_RDJ;
        end
        S_RDJ: state <= S_LATJ;
        S_LATJ: begin
          ej <= rd_body;
          state <= S_SQ0;
        end
        S_SQ0: state <= S_SQ1;
        S_SQ1: begin
          ssum <= 66'(prod);
          state <= S_SQ2;
        end
        S_SQ2: begin
          ssum <= ssum + 66'(prod);
          state <= S_SQ3;
        end
        S_SQ3: begin
          ssum <= ssum + 66'(prod);
          state <= S_NM1;
        end
        S_NM1: begin
          gm_hi <= prod[63:32];
          state <= S_NM2;
        end
        S_NM2: begin
          nlo <= prod;
          state <= S_NM3;
        end
        S_NM3: begin
          num <= {32'd0, nlo} + {prod, 32'd0};
          sh <= {4'd0, ssum};
          root <= '0;
          srem <= '0;
          step <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          sh <= {sh[67:0], 2'b00};
          srem <= s_ge ? s_rem2 - s_trial : s_rem2;
          root <= {root[33:0], s_ge};
          step <= step + 1'b1;
          if (step == 7'd34) begin
            state <= S_DEN;
          end
        end
        S_DEN: begin
          den <= den_c;
          drem <= '0;
          dn <= num;
          step <= '0;
          if (num == '0) begin
            state <= S_NEXT;
          end else if (den_c == '0) begin
            mag <= CAP;
            ovf <= 1'b1;
            state <= S_NEXT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          drem <= d_ge ? 44'(d_rem2 - d_div) : d_rem2[43:0];
          dn <= {dn[94:0], d_ge};
          step <= step + 1'b1;
          if (step == 7'd95) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (dn[95:64] != '0 || dn[63:0] > CAP - mag) begin
            mag <= CAP;
            ovf <= 1'b1;
          end else begin
            mag <= mag + dn[63:0];
          end
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (j_idx + 1'b1 < cnt) begin
            j_idx <= j_idx + 1'b1;
            state <= S_RDJ;
          end else if (i_idx + ppe_pkg::CNT_W'(2) < cnt) begin
            i_idx <= i_idx + 1'b1;
            state <= S_RDI;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (emit) begin
            energy_o <= 64'd0 - mag;
            count_o <= 7'(cnt);
            ovf_o <= ovf;
            cnt <= '0;
            dropped <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/ppe_ram.sv =====
`timescale 1ns / 1ps
module ppe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ppe_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ppe_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         s_tlast,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [71:0]  m_tdata,
  input logic         m_tuser
);

  `PPE_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled output word changed")

  `PPE_ASSERT(a_last_blocks, clk, rst, s_tvalid && s_tready && s_tlast |=> !s_tready, "input still open after last body")

  `PPE_ASSERT(a_energy_sign, clk, rst, m_tvalid |-> m_tdata[63] || (m_tdata[63:0] == 64'd0), "positive energy")

  `PPE_ASSERT(a_single_zero, clk, rst, m_tvalid && !m_tuser && (m_tdata[70:65] == 6'd0) |-> m_tdata[63:0] == 64'd0, "nonzero energy for fewer than two bodies")

endmodule

bind pairwise_potential_energy ppe_checker u_ppe_checker (.*);
